// ===== src/sbh_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// No dependencies.
package sbh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned DigWords = 8;

  // One queued schedule word; msg_end marks the final word of a padded message.
  typedef struct packed {
    logic             msg_end;
    logic [WordW-1:0] word;
  } sbh_entry_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_word(input logic [2:0] i);
    unique case (i)
      3'd0: init_word = 32'h6a09e667;
      3'd1: init_word = 32'hbb67ae85;
      3'd2: init_word = 32'h3c6ef372;
      3'd3: init_word = 32'ha54ff53a;
      3'd4: init_word = 32'h510e527f;
      3'd5: init_word = 32'h9b05688c;
      3'd6: init_word = 32'h1f83d9ab;
      default: init_word = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] r);
    unique case (r)
      6'd0:  round_const = 32'h428a2f98;  6'd1:  round_const = 32'h71374491;
      6'd2:  round_const = 32'hb5c0fbcf;  6'd3:  round_const = 32'he9b5dba5;
      6'd4:  round_const = 32'h3956c25b;  6'd5:  round_const = 32'h59f111f1;
      6'd6:  round_const = 32'h923f82a4;  6'd7:  round_const = 32'hab1c5ed5;
      6'd8:  round_const = 32'hd807aa98;  6'd9:  round_const = 32'h12835b01;
      6'd10: round_const = 32'h243185be;  6'd11: round_const = 32'h550c7dc3;
      6'd12: round_const = 32'h72be5d74;  6'd13: round_const = 32'h80deb1fe;
      6'd14: round_const = 32'h9bdc06a7;  6'd15: round_const = 32'hc19bf174;
      6'd16: round_const = 32'he49b69c1;  6'd17: round_const = 32'hefbe4786;
      6'd18: round_const = 32'h0fc19dc6;  6'd19: round_const = 32'h240ca1cc;
      6'd20: round_const = 32'h2de92c6f;  6'd21: round_const = 32'h4a7484aa;
      6'd22: round_const = 32'h5cb0a9dc;  6'd23: round_const = 32'h76f988da;
      6'd24: round_const = 32'h983e5152;  6'd25: round_const = 32'ha831c66d;
      6'd26: round_const = 32'hb00327c8;  6'd27: round_const = 32'hbf597fc7;
      6'd28: round_const = 32'hc6e00bf3;  6'd29: round_const = 32'hd5a79147;
      6'd30: round_const = 32'h06ca6351;  6'd31: round_const = 32'h14292967;
      6'd32: round_const = 32'h27b70a85;  6'd33: round_const = 32'h2e1b2138;
      6'd34: round_const = 32'h4d2c6dfc;  6'd35: round_const = 32'h53380d13;
      6'd36: round_const = 32'h650a7354;  6'd37: round_const = 32'h766a0abb;
      6'd38: round_const = 32'h81c2c92e;  6'd39: round_const = 32'h92722c85;
      6'd40: round_const = 32'ha2bfe8a1;  6'd41: round_const = 32'ha81a664b;
      6'd42: round_const = 32'hc24b8b70;  6'd43: round_const = 32'hc76c51a3;
      6'd44: round_const = 32'hd192e819;  6'd45: round_const = 32'hd6990624;
      6'd46: round_const = 32'hf40e3585;  6'd47: round_const = 32'h106aa070;
      6'd48: round_const = 32'h19a4c116;  6'd49: round_const = 32'h1e376c08;
      6'd50: round_const = 32'h2748774c;  6'd51: round_const = 32'h34b0bcb5;
      6'd52: round_const = 32'h391c0cb3;  6'd53: round_const = 32'h4ed8aa4a;
      6'd54: round_const = 32'h5b9cca4f;  6'd55: round_const = 32'h682e6ff3;
      6'd56: round_const = 32'h748f82ee;  6'd57: round_const = 32'h78a5636f;
      6'd58: round_const = 32'h84c87814;  6'd59: round_const = 32'h8cc70208;
      6'd60: round_const = 32'h90befffa;  6'd61: round_const = 32'ha4506ceb;
      6'd62: round_const = 32'hbef9a3f7;  default: round_const = 32'hc67178f2;
    endcase
  endfunction

endpackage

// ===== src/sbh_front.sv =====
// Front end: packs message bytes into big-endian words and generates padding.
// Depends on sbh_pkg.
module sbh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [7:0]        data_byte_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output sbh_pkg::sbh_entry_t push_entry_o
);
  import sbh_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_LEN_LO} state_e;

  localparam logic [3:0] LenHiSlot = 4'd14;

  state_e      state_q;
  logic [5:0]  pos_q;       // byte position in the current block
  logic [23:0] acc_q;       // last three bytes taken
  logic [63:0] total_q;     // bits in completed blocks
  logic [63:0] len_q;       // message length latched at finish
  logic [31:0] pad_q;       // word holding the 0x80 marker
  logic [3:0]  widx_q;      // word slot during padding
  logic        first_q;

  logic accept;
  logic [31:0] pad_word;

  assign in_ready_o = (state_q == ST_IDLE) && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    case (pos_q[1:0])
      2'd0:    pad_word = {8'h80, 24'h0};
      2'd1:    pad_word = {acc_q[7:0], 8'h80, 16'h0};
      2'd2:    pad_word = {acc_q[15:0], 8'h80, 8'h0};
      default: pad_word = {acc_q[23:0], 8'h80};
    endcase
  end

  always_comb begin
    push_valid_o       = 1'b0;
    push_entry_o.msg_end = 1'b0;
    push_entry_o.word  = {acc_q, data_byte_i};
    unique case (state_q)
      ST_IDLE: begin
        push_valid_o = accept && !kind_i && (pos_q[1:0] == 2'd3);
      end
      ST_FILL: begin
        push_valid_o = 1'b1;
        if (first_q) begin
          push_entry_o.word = pad_q;
        end else if (widx_q == LenHiSlot) begin
          push_entry_o.word = len_q[63:32];
        end else begin
          push_entry_o.word = '0;
        end
      end
      default: begin
        push_valid_o         = 1'b1;
        push_entry_o.word    = len_q[31:0];
        push_entry_o.msg_end = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      acc_q   <= '0;
      total_q <= '0;
      len_q   <= '0;
      pad_q   <= '0;
      widx_q  <= '0;
      first_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!kind_i) begin
              acc_q <= {acc_q[15:0], data_byte_i};
              pos_q <= pos_q + 6'd1;
              if (pos_q == 6'd63) begin
                total_q <= total_q + 64'd512;
              end
            end else begin
              len_q   <= total_q + {55'd0, pos_q, 3'b000};
              pad_q   <= pad_word;
              widx_q  <= pos_q[5:2];
              first_q <= 1'b1;
              pos_q   <= '0;
              total_q <= '0;
              state_q <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (push_ready_i) begin
            first_q <= 1'b0;
            widx_q  <= widx_q + 4'd1;
            if (!first_q && widx_q == LenHiSlot) begin
              state_q <= ST_LEN_LO;
            end
          end
        end
        default: begin
          if (push_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/sbh_queue.sv =====
// Short word queue between the byte front end and the compression back end.
// Depends on sbh_pkg.
module sbh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  sbh_pkg::sbh_entry_t wr_entry_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output sbh_pkg::sbh_entry_t rd_entry_o
);
  import sbh_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  sbh_entry_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== src/sbh_back.sv =====
// Back end: 16-word schedule window, one compression round per cycle, digest output.
// Depends on sbh_pkg.
module sbh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  sbh_pkg::sbh_entry_t q_entry_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_word_o,
  output logic [2:0]          out_index_o,
  output logic                out_last_o
);
  import sbh_pkg::*;

  typedef enum logic [1:0] {ST_COLLECT, ST_ROUND, ST_FINAL, ST_EMIT} state_e;

  state_e      state_q;
  logic [5:0]  cnt_q;
  logic        msg_q;
  logic [31:0] h_q [DigWords];
  logic [31:0] v_q [DigWords];
  logic [31:0] w_q [BlkWords];
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_index_q;
  logic        out_last_q;

  logic [31:0] v_next [DigWords];
  logic [31:0] w_new, sum1, sum2;
  logic        load_out;

  assign q_ready_o   = (state_q == ST_COLLECT);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;
  assign load_out    = !out_valid_q || out_ready_i;

  // next schedule word W[t+16] from the window holding W[t..t+15]
  assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

  always_comb begin
    sum1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + round_const(cnt_q) + w_q[0];
    sum2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    v_next[0] = sum1 + sum2;
    v_next[1] = v_q[0];
    v_next[2] = v_q[1];
    v_next[3] = v_q[2];
    v_next[4] = v_q[3] + sum1;
    v_next[5] = v_q[4];
    v_next[6] = v_q[5];
    v_next[7] = v_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      cnt_q       <= '0;
      msg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_index_q <= '0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < DigWords; i++) begin
        h_q[i] <= init_word(3'(i));
        v_q[i] <= '0;
      end
      for (int i = 0; i < BlkWords; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      // while emitting, the emit arm alone drives the output valid
      if (out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_COLLECT: begin
          if (q_valid_i) begin
            for (int i = 0; i < BlkWords - 1; i++) begin
              w_q[i] <= w_q[i+1];
            end
            w_q[BlkWords-1] <= q_entry_i.word;
            msg_q <= q_entry_i.msg_end;
            if (cnt_q[3:0] == 4'(BlkWords - 1)) begin
              cnt_q <= '0;
              for (int i = 0; i < DigWords; i++) begin
                v_q[i] <= h_q[i];
              end
              state_q <= ST_ROUND;
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < DigWords; i++) begin
            v_q[i] <= v_next[i];
          end
          for (int i = 0; i < BlkWords - 1; i++) begin
            w_q[i] <= w_q[i+1];
          end
          w_q[BlkWords-1] <= w_new;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(Rounds - 1)) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < DigWords; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          cnt_q   <= '0;
          state_q <= msg_q ? ST_EMIT : ST_COLLECT;
        end
        default: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_word_q  <= h_q[cnt_q[2:0]];
            out_index_q <= cnt_q[2:0];
            out_last_q  <= (cnt_q[2:0] == 3'(DigWords - 1));
            if (cnt_q[2:0] == 3'(DigWords - 1)) begin
              // digest is out: restore the initial chaining words
              for (int i = 0; i < DigWords; i++) begin
                h_q[i] <= init_word(3'(i));
              end
              cnt_q   <= '0;
              state_q <= ST_COLLECT;
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: front end, word queue, back end.
// Depends on sbh_pkg, sbh_front, sbh_queue, sbh_back.
//
//  channel  | dir | tdata                                | tuser         | tlast
//  s_axis   | in  | [7:0] data_byte                      | kind (1=fin)  | -
//  m_axis   | out | [31:0] digest_word, [34:32] word_idx | -             | last word
//
// The front end takes a data byte whenever it is idle and the queue has room; every fourth byte pushes a
// big-endian word into a 4-entry queue. The back end takes 16 words, then runs
// 64 rounds (one per cycle) plus a final step that folds into the chaining words.
// The queue lets the front take 16 bytes of the next block meanwhile, so in
// steady flow the throughput is set by the single round unit. A finish word
// pushes the rest of the block (up to 16 words) plus a second block of 16 when
// 56 or more bytes are pending, one per cycle while the queue has room, holding
// s_axis off meanwhile; the back end then sends eight digest words through a
// registered output, one per cycle while m_axis_tready_i is high. Reset (rst_ni
// low, async) empties the queue and loads the initial chaining words. Either side
// may stall; the queue absorbs up to four words, then s_axis is held off.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, rest 0
  output logic        m_axis_tlast_o
);
  import sbh_pkg::*;

  sbh_entry_t  push_entry, pop_entry;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sbh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .kind_i       (s_axis_tuser_i),
    .data_byte_i  (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  sbh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_entry_i (push_entry),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_entry_o (pop_entry)
  );

  sbh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_entry_i   (pop_entry),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (digest_word),
    .out_index_o (word_index),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, word_index, digest_word};

endmodule
